// File: src/pid_position_servo_macros.svh
// Assertion helpers for the servo RTL.
`ifndef PID_POSITION_SERVO_MACROS_SVH
`define PID_POSITION_SERVO_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define PPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pps check failed");

// Next-cycle implication checked outside reset.
`define PPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pps check failed");

`endif

// File: src/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Types and constants shared by the position servo modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  localparam int MUL_A_W = 31;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = 48;
  localparam int DEN_W   = 16;
  localparam int STEP_W  = 6;

  // Quotient bits needed per division
  localparam logic [STEP_W-1:0] STEPS_INTEG = 6'd46;
  localparam logic [STEP_W-1:0] STEPS_DERIV = 6'd24;
  localparam logic [STEP_W-1:0] STEPS_DUTY  = 6'd16;

  typedef enum logic [2:0] {
    REG_SETPOINT    = 3'd0,
    REG_PROP_GAIN   = 3'd1,
    REG_INTEG_GAIN  = 3'd2,
    REG_DERIV_GAIN  = 3'd3,
    REG_DRIVE_LIMIT = 3'd4,
    REG_DEAD_BAND   = 3'd5,
    REG_PWM_MIN     = 3'd6,
    REG_PWM_MAX     = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RING, S_MP, S_MI1, S_MI2, S_DI, S_WI, S_MD, S_DD, S_WD,
    S_CLAMP, S_DUTY, S_WU, S_OUT
  } seq_state_e;

  typedef struct packed {
    logic [9:0]  adc_sample;
    logic [15:0] elapsed_ms;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] fwd_duty;
    logic [7:0] rev_duty;
    logic       settled;
  } out_beat_t;

  typedef struct packed {
    logic                     start;
    logic signed [PROD_W-1:0] num;
    logic [DEN_W-1:0]         den;
    logic [STEP_W-1:0]        steps;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [PROD_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: src/pid_position_servo.sv
// ----------------------------------------------------------------------------
// pid_position_servo
// PID position loop: error ring, shared multiplier and divider, PWM duty out.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  in      | in  | in_valid_i / in_stall_o  | in_data_i  (in_beat_t)
//  out     | out | out_valid_o / out_stall_i| out_data_o (out_beat_t)
//  cfg     | in  | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// A beat keeps in_stall_o high through the sequencer states, the derivative
// division, clamp, the duty division and the output load. The integral takes
// a rounding shift, or a division when the window depth is not a power of
// two. Zero elapsed time skips the integral and derivative terms, and a
// settled drive skips the duty division.
// Reset clears the error ring (valid bits), the running sum and the settled and valid flags.
// A held result lets one more beat in, which then waits in S_OUT.
`default_nettype none

module pid_position_servo
  import pps_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_beat_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_beat_t        out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

`include "pid_position_servo_macros.svh"

  localparam int SUM_W      = $clog2(WINDOW_DEPTH) + 8;
  localparam int DEPTH_SH   = $clog2(WINDOW_DEPTH);
  localparam bit DEPTH_POW2 = (WINDOW_DEPTH & (WINDOW_DEPTH - 1)) == 0;

  // Configuration registers
  logic [6:0]         setpoint_q, limit_q;
  logic signed [15:0] kp_q, ki_q, kd_q;
  logic [14:0]        db_q;
  logic [7:0]         pmin_q, pmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= '0;
      kp_q       <= '0;
      ki_q       <= '0;
      kd_q       <= '0;
      limit_q    <= 7'd30;
      db_q       <= 15'd192;
      pmin_q     <= 8'd80;
      pmax_q     <= 8'd250;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SETPOINT:    setpoint_q <= cfg_data_i[6:0];
        REG_PROP_GAIN:   kp_q       <= cfg_data_i;
        REG_INTEG_GAIN:  ki_q       <= cfg_data_i;
        REG_DERIV_GAIN:  kd_q       <= cfg_data_i;
        REG_DRIVE_LIMIT: limit_q    <= cfg_data_i[6:0];
        REG_DEAD_BAND:   db_q       <= cfg_data_i[14:0];
        REG_PWM_MIN:     pmin_q     <= cfg_data_i[7:0];
        REG_PWM_MAX:     pmax_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and work registers
  seq_state_e               state_q, state_d;
  logic signed [7:0]        err_q, err_d, prev_q, prev_d;
  logic signed [8:0]        diff_q, diff_d;
  logic [15:0]              elap_q, elap_d;
  logic signed [PROD_W-1:0] acc_q, acc_d;
  logic                     settled_q, settled_d;
  logic                     fwd_dir_q, fwd_dir_d;
  logic [7:0]               fwd_q, fwd_d, rev_q, rev_d;
  logic                     ovalid_q, ovalid_d;
  out_beat_t                odata_q, odata_d;

  logic                     push;
  logic signed [SUM_W-1:0]  sum;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  div_req_t                 dreq;
  div_rsp_t                 drsp;
  logic                     div_wait;

  // Input error: sample/10 by reciprocal, exact over the 10-bit range
  logic [17:0]       samp_x;
  logic [6:0]        samp_div;
  logic signed [7:0] err_in;
  assign samp_x   = 18'(in_data_i.adc_sample) * 18'd205;
  assign samp_div = samp_x[17:11];
  assign err_in   = $signed({1'b0, samp_div}) - $signed({1'b0, setpoint_q});

  // Integral divided by the window depth, truncated toward zero
  logic signed [PROD_W-1:0] integ_bias, integ_shr;
  assign integ_bias = prod[PROD_W-1] ? PROD_W'(WINDOW_DEPTH - 1) : '0;
  assign integ_shr  = (prod + integ_bias) >>> DEPTH_SH;

  // Clamp and dead band on the accumulated drive
  logic signed [PROD_W-1:0] lim_s, db_s, drv, drv_mag;
  logic [6:0]               whole;
  logic signed [8:0]        span;
  logic [DEN_W-1:0]         lim_den;
  assign lim_s   = $signed(PROD_W'({limit_q, 8'd0}));
  assign db_s    = $signed(PROD_W'(db_q));
  assign drv     = (acc_q > lim_s) ? lim_s : ((acc_q < -lim_s) ? -lim_s : acc_q);
  assign drv_mag = drv[PROD_W-1] ? -drv : drv;
  assign whole   = drv_mag[14:8];
  assign span    = $signed({1'b0, pmax_q}) - $signed({1'b0, pmin_q});
  assign lim_den = (limit_q == 7'd0) ? DEN_W'(1) : DEN_W'(limit_q);

  assign in_stall_o = (state_q != S_IDLE);
  assign div_wait   = (state_q == S_WI) || (state_q == S_WD) || (state_q == S_WU);

  always_comb begin
    state_d   = state_q;
    err_d     = err_q;
    prev_d    = prev_q;
    diff_d    = diff_q;
    elap_d    = elap_q;
    acc_d     = acc_q;
    settled_d = settled_q;
    fwd_dir_d = fwd_dir_q;
    fwd_d     = fwd_q;
    rev_d     = rev_q;
    ovalid_d  = ovalid_q && out_stall_i;
    odata_d   = odata_q;
    push      = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    dreq      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          err_d   = err_in;
          elap_d  = in_data_i.elapsed_ms;
          state_d = S_RING;
        end
      end
      S_RING: begin
        push    = 1'b1;
        diff_d  = 9'(err_q) - 9'(prev_q);
        prev_d  = err_q;
        state_d = S_MP;
      end
      S_MP: begin
        mul_a   = MUL_A_W'(kp_q);
        mul_b   = MUL_B_W'(err_q);
        state_d = S_MI1;
      end
      S_MI1: begin
        acc_d   = prod;
        mul_a   = MUL_A_W'(ki_q);
        mul_b   = MUL_B_W'(sum);
        state_d = (elap_q == 16'd0) ? S_CLAMP : S_MI2;
      end
      S_MI2: begin
        mul_a   = MUL_A_W'(prod);
        mul_b   = $signed({1'b0, elap_q});
        state_d = S_DI;
      end
      S_DI: begin
        if (DEPTH_POW2) begin
          acc_d   = acc_q + integ_shr;
          state_d = S_MD;
        end else begin
          dreq.start = 1'b1;
          dreq.num   = prod;
          dreq.den   = DEN_W'(WINDOW_DEPTH);
          dreq.steps = STEPS_INTEG;
          state_d    = S_WI;
        end
      end
      S_WI: begin
        if (drsp.done) begin
          acc_d   = acc_q + drsp.quo;
          state_d = S_MD;
        end
      end
      S_MD: begin
        mul_a   = MUL_A_W'(kd_q);
        mul_b   = MUL_B_W'(diff_q);
        state_d = S_DD;
      end
      S_DD: begin
        dreq.start = 1'b1;
        dreq.num   = prod;
        dreq.den   = elap_q;
        dreq.steps = STEPS_DERIV;
        state_d    = S_WD;
      end
      S_WD: begin
        if (drsp.done) begin
          acc_d   = acc_q + drsp.quo;
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        fwd_d = '0;
        rev_d = '0;
        if (drv < -db_s || drv > db_s) begin
          fwd_dir_d = drv[PROD_W-1];
          mul_a     = MUL_A_W'({1'b0, whole});
          mul_b     = MUL_B_W'(span);
          state_d   = S_DUTY;
        end else begin
          settled_d = 1'b1;
          state_d   = S_OUT;
        end
      end
      S_DUTY: begin
        dreq.start = 1'b1;
        dreq.num   = prod;
        dreq.den   = lim_den;
        dreq.steps = STEPS_DUTY;
        state_d    = S_WU;
      end
      S_WU: begin
        if (drsp.done) begin
          // Duty wraps to 8 bits, so only the low quotient byte matters
          if (fwd_dir_q) begin
            fwd_d = pmin_q + drsp.quo[7:0];
          end else begin
            rev_d = pmin_q + drsp.quo[7:0];
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d         = 1'b1;
          odata_d.fwd_duty = fwd_q;
          odata_d.rev_duty = rev_q;
          odata_d.settled  = settled_q;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      prev_q    <= '0;
      settled_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      prev_q    <= prev_d;
      settled_q <= settled_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q     <= err_d;
    diff_q    <= diff_d;
    elap_q    <= elap_d;
    acc_q     <= acc_d;
    fwd_dir_q <= fwd_dir_d;
    fwd_q     <= fwd_d;
    rev_q     <= rev_d;
    odata_q   <= odata_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  pps_ring #(.DEPTH(WINDOW_DEPTH)) u_ring (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .err_i (err_q),
    .sum_o (sum)
  );

  pps_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  pps_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  `PPS_ASSERT_NXT(a_accept_ring, in_valid_i && !in_stall_o, state_q == S_RING)
  `PPS_ASSERT_IMP(a_div_busy_wait, drsp.busy, div_wait)
  `PPS_ASSERT_IMP(a_one_dir, out_valid_o && out_data_o.fwd_duty != 8'd0, out_data_o.rev_duty == 8'd0)
  `PPS_ASSERT_NXT(a_settled_sticky, settled_q, settled_q)

endmodule

`default_nettype wire

// File: src/pps_mul.sv
// ----------------------------------------------------------------------------
// pps_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_mul
  import pps_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic signed [MUL_A_W-1:0] a_i,
  input  wire logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]       p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: src/pps_div.sv
// ----------------------------------------------------------------------------
// pps_div
// Shared restoring divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_div
  import pps_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                busy_q, done_q, neg_q;
  logic [STEP_W-1:0]   cnt_q;
  logic [PROD_W-1:0]   num_q, quo_q;
  logic [DEN_W-1:0]    rem_q, den_q;
  logic [PROD_W-1:0]   mag;
  logic [DEN_W:0]      rem_sh;
  logic                ge;

  assign mag    = req_i.num[PROD_W-1] ? PROD_W'(-req_i.num) : PROD_W'(req_i.num);
  assign rem_sh = {rem_q, num_q[PROD_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= mag << (STEP_W'(PROD_W) - req_i.steps);
      neg_q <= req_i.num[PROD_W-1];
      den_q <= req_i.den;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);
      quo_q <= {quo_q[PROD_W-2:0], ge};
      num_q <= {num_q[PROD_W-2:0], 1'b0};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

`default_nettype wire

// File: src/pps_ring.sv
// ----------------------------------------------------------------------------
// pps_ring
// Ring of past errors with a running sum over the window.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_ring #(
  parameter int DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic signed [7:0] err_i,
  output logic signed [$clog2(DEPTH)+7:0] sum_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int SUM_W = IDX_W + 8;

  logic signed [7:0]       mem [DEPTH];
  logic [DEPTH-1:0]        valid_q;
  logic [IDX_W-1:0]        idx_q;
  logic signed [7:0]       rd_q;
  logic signed [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[idx_q] <= err_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      idx_q   <= '0;
      rd_q    <= '0;
      sum_q   <= '0;
    end else begin
      // Oldest entry, read at the slot the next push overwrites
      rd_q <= valid_q[idx_q] ? mem[idx_q] : 8'sd0;
      if (push_i) begin
        valid_q[idx_q] <= 1'b1;
        idx_q <= (idx_q == IDX_W'(DEPTH - 1)) ? '0 : idx_q + 1'b1;
        sum_q <= sum_q - SUM_W'(rd_q) + SUM_W'(err_i);
      end
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire
